// ===== src/wfd_pkg.sv =====
package wfd_pkg;

  localparam int ACTIVE_SLOTS = 64;
  localparam int EDGE_SLOTS   = 64;
  localparam int ID_W         = 64;
  localparam int RC_W         = 7;
  localparam int RC_MAX       = (1 << RC_W) - 1;

  typedef enum logic [1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_UNREGISTER = 2'd1,
    KIND_WAIT       = 2'd2,
    KIND_NONE       = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_PROCEED  = 3'd1,
    ST_WAIT     = 3'd2,
    ST_CIRCULAR = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_ACT_SET,
    CELL_UNREG,
    CELL_EDGE_SET,
    CELL_EDGE_CLR
  } cell_op_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] txn_id;
    logic [ID_W-1:0] prereq_id;
  } in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [RC_W-1:0] released_count;
  } out_t;

  // Broadcast command to every cell of both rows
  typedef struct packed {
    cell_op_e        op;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] waiter;
    logic [ID_W-1:0] target;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic first;
  } act_stat_t;

  typedef struct packed {
    logic            hit;
    logic            tgt_hit;
    logic            first;
    logic [ID_W-1:0] rd_target;
  } edge_stat_t;

endpackage

// ===== src/wfd_act_cell.sv =====
module wfd_act_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfd_pkg::cell_cmd_t  cmd_i,
  input  logic                sel_i,
  input  logic                free_seen_i,
  output logic                free_seen_o,
  output wfd_pkg::act_stat_t  stat_o
);

  logic                     valid_q;
  logic [wfd_pkg::ID_W-1:0] ident_q;
  logic                     hit;

  // Match the broadcast key and pass the free-slot token along the row
  assign hit          = valid_q && (ident_q == cmd_i.key);
  assign free_seen_o  = free_seen_i || !valid_q;
  assign stat_o.hit   = hit;
  assign stat_o.first = !valid_q && !free_seen_i;

  // Hold the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        wfd_pkg::CELL_ACT_SET: if (sel_i) valid_q <= 1'b1;
        wfd_pkg::CELL_UNREG:   if (hit) valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Capture the id
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wfd_pkg::CELL_ACT_SET && sel_i) begin
      ident_q <= cmd_i.key;
    end
  end

endmodule

// ===== src/wfd_edge_cell.sv =====
module wfd_edge_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wfd_pkg::cell_cmd_t  cmd_i,
  input  logic                sel_i,
  input  logic                free_seen_i,
  output logic                free_seen_o,
  output wfd_pkg::edge_stat_t stat_o
);

  logic                     valid_q;
  logic [wfd_pkg::ID_W-1:0] waiter_q;
  logic [wfd_pkg::ID_W-1:0] target_q;
  logic                     hit;
  logic                     tgt_hit;

  // Match waiter and target against the key; pass the free-slot token on
  assign hit              = valid_q && (waiter_q == cmd_i.key);
  assign tgt_hit          = valid_q && (target_q == cmd_i.key);
  assign free_seen_o      = free_seen_i || !valid_q;
  assign stat_o.hit       = hit;
  assign stat_o.tgt_hit   = tgt_hit;
  assign stat_o.first     = !valid_q && !free_seen_i;
  assign stat_o.rd_target = hit ? target_q : '0;

  // Hold the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        wfd_pkg::CELL_EDGE_SET: if (sel_i) valid_q <= 1'b1;
        wfd_pkg::CELL_EDGE_CLR: if (sel_i) valid_q <= 1'b0;
        wfd_pkg::CELL_UNREG:    if (tgt_hit) valid_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Capture the edge
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wfd_pkg::CELL_EDGE_SET && sel_i) begin
      waiter_q <= cmd_i.waiter;
      target_q <= cmd_i.target;
    end
  end

endmodule

// ===== src/wait_for_deadlock_detector_top.sv =====
// Wait-for deadlock detector: one result per request, one request at a time.
// An unused kind goes straight to the finish state, where the result register
// loads. Register, unregister and a wait whose prerequisite is not active
// first pass through S_REG, S_UNREG or S_W_ACT; a wait that finds the edge
// table full passes through S_W_ACT and S_W_EDGE. A wait that walks the chain
// then does one associative lookup over the edge row per cycle, for at most
// EDGE_SLOTS lookups. The block returns to idle as the result register loads
// and takes the next request from idle. A finished result sits in the output
// register, so a stalled result holds the block only once the following
// request has finished.
module wait_for_deadlock_detector_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wfd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wfd_pkg::out_t out_data_o
);

  localparam int A_N   = wfd_pkg::ACTIVE_SLOTS;
  localparam int E_N   = wfd_pkg::EDGE_SLOTS;
  localparam int STP_W = $clog2(E_N);

  typedef enum logic [2:0] {
    S_IDLE, S_REG, S_UNREG, S_W_ACT, S_W_EDGE, S_W_WALK, S_FIN
  } state_e;

  state_e                    state_q;
  logic [1:0]                kind_q;
  logic [wfd_pkg::ID_W-1:0]  id_q;
  logic [wfd_pkg::ID_W-1:0]  pre_q;
  logic [wfd_pkg::ID_W-1:0]  cur_q;
  logic [STP_W-1:0]          steps_q;
  logic [E_N-1:0]            slot_q;
  logic [2:0]                res_status_q;
  logic [wfd_pkg::RC_W-1:0]  res_count_q;
  logic                      out_valid_q;
  wfd_pkg::out_t             out_q;

  wfd_pkg::cell_cmd_t        cmd;
  logic [A_N-1:0]            act_sel;
  logic [E_N-1:0]            edge_sel;
  wfd_pkg::act_stat_t        act_stat [A_N];
  wfd_pkg::edge_stat_t       edge_stat [E_N];
  logic [A_N:0]              act_chain;
  logic [E_N:0]              edge_chain;
  logic [A_N-1:0]            act_hit_v;
  logic [A_N-1:0]            act_first_v;
  logic [E_N-1:0]            edge_hit_v;
  logic [E_N-1:0]            edge_first_v;
  logic [E_N-1:0]            tgt_hit_v;
  logic [wfd_pkg::ID_W-1:0]  rd_target;
  logic [wfd_pkg::RC_W-1:0]  rel_count;
  int unsigned               rel_raw;

  // Rows of cells
  assign act_chain[0]  = 1'b0;
  assign edge_chain[0] = 1'b0;

  for (genvar i = 0; i < A_N; i++) begin : g_act
    wfd_act_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .sel_i       (act_sel[i]),
      .free_seen_i (act_chain[i]),
      .free_seen_o (act_chain[i+1]),
      .stat_o      (act_stat[i])
    );
    assign act_hit_v[i]   = act_stat[i].hit;
    assign act_first_v[i] = act_stat[i].first;
  end

  for (genvar i = 0; i < E_N; i++) begin : g_edge
    wfd_edge_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .sel_i       (edge_sel[i]),
      .free_seen_i (edge_chain[i]),
      .free_seen_o (edge_chain[i+1]),
      .stat_o      (edge_stat[i])
    );
    assign edge_hit_v[i]   = edge_stat[i].hit;
    assign edge_first_v[i] = edge_stat[i].first;
    assign tgt_hit_v[i]    = edge_stat[i].tgt_hit;
  end

  // Gather the target of the single matching edge
  always_comb begin
    rd_target = '0;
    for (int i = 0; i < E_N; i++) begin
      rd_target = rd_target | edge_stat[i].rd_target;
    end
  end

  // Count released waiters, saturated
  assign rel_raw   = $countones(tgt_hit_v);
  assign rel_count = (rel_raw > wfd_pkg::RC_MAX) ? wfd_pkg::RC_W'(wfd_pkg::RC_MAX)
                                                 : wfd_pkg::RC_W'(rel_raw);

  // Drive the broadcast command
  always_comb begin
    cmd.op     = wfd_pkg::CELL_NOP;
    cmd.key    = id_q;
    cmd.waiter = id_q;
    cmd.target = pre_q;
    act_sel    = '0;
    edge_sel   = '0;
    case (state_q)
      S_REG: begin
        if (act_hit_v == '0) begin
          cmd.op  = wfd_pkg::CELL_ACT_SET;
          act_sel = act_first_v;
        end
      end
      S_UNREG: cmd.op = wfd_pkg::CELL_UNREG;
      S_W_ACT: cmd.key = pre_q;
      S_W_EDGE: begin
        cmd.op   = wfd_pkg::CELL_EDGE_SET;
        edge_sel = (edge_hit_v != '0) ? edge_hit_v : edge_first_v;
      end
      S_W_WALK: begin
        cmd.key = cur_q;
        if (edge_hit_v != '0 && rd_target == id_q) begin
          cmd.op   = wfd_pkg::CELL_EDGE_CLR;
          edge_sel = slot_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequence one request and hold the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      kind_q       <= '0;
      id_q         <= '0;
      pre_q        <= '0;
      cur_q        <= '0;
      steps_q      <= '0;
      slot_q       <= '0;
      res_status_q <= '0;
      res_count_q  <= '0;
      out_q        <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q      <= in_data_i.kind;
            id_q        <= in_data_i.txn_id;
            pre_q       <= in_data_i.prereq_id;
            res_count_q <= '0;
            case (wfd_pkg::kind_e'(in_data_i.kind))
              wfd_pkg::KIND_REGISTER:   state_q <= S_REG;
              wfd_pkg::KIND_UNREGISTER: state_q <= S_UNREG;
              wfd_pkg::KIND_WAIT:       state_q <= S_W_ACT;
              default: begin
                res_status_q <= wfd_pkg::ST_DONE;
                state_q      <= S_FIN;
              end
            endcase
          end
        end
        S_REG: begin
          if (act_hit_v != '0 || act_first_v != '0) begin
            res_status_q <= wfd_pkg::ST_DONE;
          end else begin
            res_status_q <= wfd_pkg::ST_FULL;
          end
          state_q <= S_FIN;
        end
        S_UNREG: begin
          res_status_q <= wfd_pkg::ST_DONE;
          res_count_q  <= rel_count;
          state_q      <= S_FIN;
        end
        S_W_ACT: begin
          if (act_hit_v == '0) begin
            res_status_q <= wfd_pkg::ST_PROCEED;
            state_q      <= S_FIN;
          end else begin
            state_q <= S_W_EDGE;
          end
        end
        S_W_EDGE: begin
          if (edge_hit_v == '0 && edge_first_v == '0) begin
            res_status_q <= wfd_pkg::ST_FULL;
            state_q      <= S_FIN;
          end else begin
            slot_q  <= edge_sel;
            cur_q   <= pre_q;
            steps_q <= '0;
            state_q <= S_W_WALK;
          end
        end
        S_W_WALK: begin
          // Advance one edge along the chain per cycle
          if (edge_hit_v == '0) begin
            res_status_q <= wfd_pkg::ST_WAIT;
            state_q      <= S_FIN;
          end else if (rd_target == id_q) begin
            res_status_q <= wfd_pkg::ST_CIRCULAR;
            state_q      <= S_FIN;
          end else if (steps_q == STP_W'(E_N - 1)) begin
            res_status_q <= wfd_pkg::ST_WAIT;
            state_q      <= S_FIN;
          end else begin
            cur_q   <= rd_target;
            steps_q <= steps_q + 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.status         <= res_status_q;
            out_q.released_count <= (wfd_pkg::kind_e'(kind_q) == wfd_pkg::KIND_UNREGISTER)
                                    ? res_count_q : '0;
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
